@@ src/ppm_p6_pkg.sv @@
// ----------------------------------------------------------------------------
// PPM P6 decoder package
// Shared types, result codes and character constants for the PPM P6
// byte-stream decoder.
// ----------------------------------------------------------------------------
package ppm_p6_pkg;

    localparam int DIM_BITS_DEFAULT = 16;
    localparam int RESULT_DEPTH     = 4;

    // Result kinds carried in the output beat.
    typedef enum logic [2:0] {
        KIND_PIXEL        = 3'd0,
        KIND_HEADER       = 3'd1,
        KIND_FORMAT_ERROR = 3'd2,
        KIND_SIZE_ERROR   = 3'd3,
        KIND_TRUNCATED    = 3'd4,
        KIND_DONE         = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TOKEN,
        PH_PIXELS,
        PH_FIN
    } phase_t;

    // Progress through the magic word.
    localparam logic [1:0] MAGIC_NONE = 2'd0;
    localparam logic [1:0] MAGIC_P    = 2'd1;
    localparam logic [1:0] MAGIC_P6   = 2'd2;
    localparam logic [1:0] MAGIC_BAD  = 2'd3;

    // Configuration register indexes.
    localparam logic [0:0] CFG_MAX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_MAX_HEIGHT = 1'b1;

    localparam logic [1:0] LAST_TOKEN = 2'd3;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SIX   = 8'h36;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [16:0] MAX_VALUE = 17'd255;
    localparam logic [16:0] ACC_CAP   = 17'd65536;
    localparam logic [16:0] DIM_LIMIT = 17'd65535;

    typedef struct packed {
        logic stop;
        logic neg;
        logic digit;
    } token_flags_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_data_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red_value;
        logic [7:0]  green_value;
        logic [7:0]  blue_value;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last;
    } out_data_t;

endpackage

@@ src/ppm_p6_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream decoder
// Parses a P6 header from a byte stream and emits RGB pixels with their
// position, plus header, error, truncation and completion results.
// ----------------------------------------------------------------------------
// Results of a byte are written to a result queue whose head drives the output.
// Throughput: one input byte per cycle while in_stall is low; a byte can yield
// two results, absorbed by a four-entry result queue.
// Reset: rst_n clears parser state and the queue and sets both size limits to
// 65535. An end-of-stream beat returns the parser to its reset state.
module ppm_p6_stream_decoder
    import ppm_p6_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_data_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_data_t   out_data,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PTR_BITS = $clog2(RESULT_DEPTH);
    localparam int CNT_BITS = $clog2(RESULT_DEPTH + 1);
    localparam logic [15:0] DIM_CAP = 16'((17'(1) << DIM_BITS) - 17'(1));

    // Configuration
    logic [15:0] max_width_reg;
    logic [15:0] max_height_reg;

    // Parser state
    phase_t                phase_reg, phase_next;
    logic [1:0]            token_number_reg, token_number_next;
    logic                  in_comment_reg, in_comment_next;
    logic [1:0]            magic_reg, magic_next;
    logic [16:0]           acc_reg, acc_next;
    token_flags_t          flags_reg, flags_next;
    logic [15:0]           width_reg, width_next;
    logic [15:0]           height_reg, height_next;
    logic [1:0]            comp_reg, comp_next;
    logic [7:0]            held_red_reg, held_red_next;
    logic [7:0]            held_green_reg, held_green_next;
    logic [DIM_BITS-1:0]   col_reg, col_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic                  fmt_bad_reg, fmt_bad_next;
    logic                  size_bad_reg, size_bad_next;

    // Result queue
    out_data_t             queue_reg [RESULT_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;

    logic [7:0]  c;
    logic        eos;
    logic        is_ws;
    logic        is_hash;
    logic        is_digit;
    logic        in_fire;
    logic        out_fire;

    // Token character update
    logic          tc_first;
    logic [1:0]    tc_magic;
    logic [16:0]   tc_acc;
    token_flags_t  tc_flags;
    logic [16:0]   base_acc;
    token_flags_t  base_flags;
    logic [20:0]   acc_wide;

    // Token close and header check
    logic          ct_fmt;
    logic          ct_size;
    logic [15:0]   ct_width;
    logic [15:0]   ct_height;
    logic [15:0]   lim_width;
    logic [15:0]   lim_height;
    logic          hdr_fmt;
    logic          hdr_size;

    logic [DIM_BITS-1:0] col_inc;
    logic [DIM_BITS-1:0] row_inc;

    out_data_t   res0, res1;
    logic [1:0]  res_count;

    function automatic out_data_t status_result(kind_t k, logic is_last);
        out_data_t r;
        r      = '0;
        r.kind = k;
        r.last = is_last;
        return r;
    endfunction

    assign c        = in_data.data_byte;
    assign eos      = in_data.end_of_stream;
    assign is_hash  = (c == CHAR_HASH);
    assign is_ws    = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

    assign in_stall  = (count_reg > CNT_BITS'(RESULT_DEPTH - 2));
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign out_data  = queue_reg[rd_ptr_reg];

    assign col_inc = col_reg + DIM_BITS'(1);
    assign row_inc = row_reg + DIM_BITS'(1);

    // One character of a token. A token's first character starts afresh.
    assign tc_first   = (phase_reg == PH_SKIP);
    assign base_acc   = tc_first ? '0 : acc_reg;
    assign base_flags = tc_first ? '0 : flags_reg;
    // The low nibble of an ASCII digit is its value.
    assign acc_wide   = (21'(base_acc) << 3) + (21'(base_acc) << 1) + 21'(c[3:0]);

    always_comb
    begin
        tc_magic = magic_reg;
        tc_acc   = acc_reg;
        tc_flags = flags_reg;
        if (token_number_reg == 2'd0)
        begin
            if (tc_first)
                tc_magic = (c == CHAR_P) ? MAGIC_P : MAGIC_BAD;
            else
                tc_magic = (magic_reg == MAGIC_P && c == CHAR_SIX) ? MAGIC_P6 : MAGIC_BAD;
        end
        else if (tc_first && c == CHAR_MINUS)
        begin
            tc_acc   = '0;
            tc_flags = '{stop: 1'b0, neg: 1'b1, digit: 1'b0};
        end
        else if (tc_first && c == CHAR_PLUS)
        begin
            tc_acc   = '0;
            tc_flags = '0;
        end
        else if (base_flags.stop)
        begin
            tc_acc   = base_acc;
            tc_flags = base_flags;
        end
        else if (is_digit)
        begin
            tc_acc         = (acc_wide > 21'(ACC_CAP)) ? ACC_CAP : acc_wide[16:0];
            tc_flags       = base_flags;
            tc_flags.digit = 1'b1;
        end
        else
        begin
            tc_acc        = base_acc;
            tc_flags      = base_flags;
            tc_flags.stop = 1'b1;
        end
    end

    // Closing a token: record dimensions and collect header errors.
    always_comb
    begin
        ct_fmt    = fmt_bad_reg;
        ct_size   = size_bad_reg;
        ct_width  = width_reg;
        ct_height = height_reg;
        case (token_number_reg)
            2'd1, 2'd2:
            begin
                if (!flags_reg.digit)
                    ct_fmt = 1'b1;
                else if ((flags_reg.neg && acc_reg != '0) || acc_reg > DIM_LIMIT)
                    ct_size = 1'b1;
                if (token_number_reg == 2'd1)
                    ct_width = acc_reg[15:0];
                else
                    ct_height = acc_reg[15:0];
            end
            LAST_TOKEN:
            begin
                if (!flags_reg.digit || flags_reg.neg || acc_reg != MAX_VALUE)
                    ct_fmt = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign lim_width  = (max_width_reg < DIM_CAP) ? max_width_reg : DIM_CAP;
    assign lim_height = (max_height_reg < DIM_CAP) ? max_height_reg : DIM_CAP;
    assign hdr_fmt    = (magic_reg != MAGIC_P6) || ct_fmt;
    assign hdr_size   = ct_size || ct_width == '0 || ct_height == '0 ||
                        ct_width > lim_width || ct_height > lim_height;

    // Next parser state and the results of the current byte.
    always_comb
    begin
        phase_next        = phase_reg;
        token_number_next = token_number_reg;
        in_comment_next   = in_comment_reg;
        magic_next        = magic_reg;
        acc_next          = acc_reg;
        flags_next        = flags_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        comp_next         = comp_reg;
        held_red_next     = held_red_reg;
        held_green_next   = held_green_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        fmt_bad_next      = fmt_bad_reg;
        size_bad_next     = size_bad_reg;
        res0              = status_result(KIND_PIXEL, 1'b0);
        res1              = status_result(KIND_PIXEL, 1'b0);
        res_count         = 2'd0;

        if (eos)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    res0      = status_result(KIND_FORMAT_ERROR, 1'b1);
                    res_count = 2'd1;
                end
                PH_TOKEN:
                begin
                    res_count = 2'd1;
                    if (token_number_reg != LAST_TOKEN || hdr_fmt)
                        res0 = status_result(KIND_FORMAT_ERROR, 1'b1);
                    else if (hdr_size)
                        res0 = status_result(KIND_SIZE_ERROR, 1'b1);
                    else
                    begin
                        // Header is good but the stream ends before any pixel.
                        res0              = status_result(KIND_HEADER, 1'b0);
                        res0.image_width  = ct_width;
                        res0.image_height = ct_height;
                        res1              = status_result(KIND_TRUNCATED, 1'b1);
                        res_count         = 2'd2;
                    end
                end
                PH_PIXELS:
                begin
                    res0      = status_result(KIND_TRUNCATED, 1'b1);
                    res_count = 2'd1;
                end
                default:
                begin
                end
            endcase
            phase_next        = PH_SKIP;
            token_number_next = '0;
            in_comment_next   = 1'b0;
            magic_next        = MAGIC_NONE;
            acc_next          = '0;
            flags_next        = '0;
            width_next        = '0;
            height_next       = '0;
            comp_next         = '0;
            held_red_next     = '0;
            held_green_next   = '0;
            col_next          = '0;
            row_next          = '0;
            fmt_bad_next      = 1'b0;
            size_bad_next     = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (in_comment_reg)
                    begin
                        if (c == CHAR_NL)
                            in_comment_next = 1'b0;
                    end
                    else if (is_hash)
                        in_comment_next = 1'b1;
                    else if (!is_ws)
                    begin
                        magic_next = tc_magic;
                        acc_next   = tc_acc;
                        flags_next = tc_flags;
                        phase_next = PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    if (is_ws || is_hash)
                    begin
                        fmt_bad_next  = ct_fmt;
                        size_bad_next = ct_size;
                        width_next    = ct_width;
                        height_next   = ct_height;
                        if (token_number_reg == LAST_TOKEN)
                        begin
                            res_count = 2'd1;
                            if (hdr_fmt)
                            begin
                                res0       = status_result(KIND_FORMAT_ERROR, 1'b1);
                                phase_next = PH_FIN;
                            end
                            else if (hdr_size)
                            begin
                                res0       = status_result(KIND_SIZE_ERROR, 1'b1);
                                phase_next = PH_FIN;
                            end
                            else
                            begin
                                res0              = status_result(KIND_HEADER, 1'b1);
                                res0.image_width  = ct_width;
                                res0.image_height = ct_height;
                                phase_next        = PH_PIXELS;
                                col_next          = '0;
                                row_next          = '0;
                                comp_next         = 2'd0;
                                // A '#' right after the maximum value is pixel data.
                                if (is_hash)
                                begin
                                    held_red_next = c;
                                    comp_next     = 2'd1;
                                end
                            end
                        end
                        else
                        begin
                            token_number_next = token_number_reg + 2'd1;
                            phase_next        = PH_SKIP;
                            in_comment_next   = is_hash;
                        end
                    end
                    else
                    begin
                        magic_next = tc_magic;
                        acc_next   = tc_acc;
                        flags_next = tc_flags;
                    end
                end
                PH_PIXELS:
                begin
                    case (comp_reg)
                        2'd0:
                        begin
                            held_red_next = c;
                            comp_next     = 2'd1;
                        end
                        2'd1:
                        begin
                            held_green_next = c;
                            comp_next       = 2'd2;
                        end
                        default:
                        begin
                            comp_next        = 2'd0;
                            res0             = status_result(KIND_PIXEL, 1'b1);
                            res0.red_value   = held_red_reg;
                            res0.green_value = held_green_reg;
                            res0.blue_value  = c;
                            res0.column      = 16'(col_reg);
                            res0.row         = 16'(row_reg);
                            res_count        = 2'd1;
                            if (16'(col_inc) == width_reg)
                            begin
                                col_next = '0;
                                row_next = row_inc;
                                if (16'(row_inc) == height_reg)
                                begin
                                    phase_next = PH_FIN;
                                    res0.last  = 1'b0;
                                    res1       = status_result(KIND_DONE, 1'b1);
                                    res_count  = 2'd2;
                                end
                            end
                            else
                                col_next = col_inc;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg  <= 16'hFFFF;
            max_height_reg <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_WIDTH:  max_width_reg  <= cfg_data;
                CFG_MAX_HEIGHT: max_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SKIP;
            token_number_reg <= '0;
            in_comment_reg   <= 1'b0;
            magic_reg        <= MAGIC_NONE;
            acc_reg          <= '0;
            flags_reg        <= '0;
            comp_reg         <= '0;
            held_red_reg     <= '0;
            held_green_reg   <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            fmt_bad_reg      <= 1'b0;
            size_bad_reg     <= 1'b0;
            width_reg        <= '0;
            height_reg       <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            token_number_reg <= token_number_next;
            in_comment_reg   <= in_comment_next;
            magic_reg        <= magic_next;
            acc_reg          <= acc_next;
            flags_reg        <= flags_next;
            comp_reg         <= comp_next;
            held_red_reg     <= held_red_next;
            held_green_reg   <= held_green_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            fmt_bad_reg      <= fmt_bad_next;
            size_bad_reg     <= size_bad_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
        end
    end

    // Result queue: up to two results are written per beat, one is read.
    always_ff @(posedge clk)
    begin
        if (in_fire && res_count != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (in_fire && res_count == 2'd2)
            queue_reg[wr_ptr_reg + PTR_BITS'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(res_count);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_reg + (in_fire ? CNT_BITS'(res_count) : '0)
                         - CNT_BITS'(out_fire);
        end
    end

    // Assertions
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(RESULT_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && eos) |=> (phase_reg == PH_SKIP && token_number_reg == '0))
        else $error("parser did not rearm after end of stream");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (16'(col_reg) < width_reg && comp_reg != 2'd3))
        else $error("pixel position or component count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !in_fire) |=> (count_reg == $past(count_reg) - CNT_BITS'(1)))
        else $error("result count did not drop on a pop");

endmodule

@@ sim/ppm_p6_stream_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream decoder testbench
// Feeds byte streams of PPM files to the decoder. Most are well-formed
// headers with comments, signs and leading zeros, followed by pixel data;
// the rest have a broken magic word, bad numbers, cut-off streams or random
// noise. Every input beat is run through a behavioral decoder in a
// scoreboard, and each output beat is checked against the oldest expected
// result. Both size limits are reprogrammed between phases, and the two
// channels stall at random, with two long hold-offs on the result side.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_tb;
    import ppm_p6_pkg::*;

    localparam int DIM_BITS        = DIM_BITS_DEFAULT;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 5000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [1:0] TOKEN_WIDTH  = 2'd1;
    localparam logic [1:0] TOKEN_HEIGHT = 2'd2;

    // Behavioral decoder plus the queue of results it still expects.
    class decode_tracker;
        out_data_t    pending_beats[$];
        int           failures;
        logic [15:0]  width_limit;
        logic [15:0]  height_limit;

        phase_t       phase;
        logic [1:0]   token_number;
        logic         in_comment;
        logic [1:0]   magic;
        logic [16:0]  acc;
        token_flags_t flags;
        logic [15:0]  width_reg;
        logic [15:0]  height_reg;
        logic [1:0]   comp_count;
        logic [7:0]   held_red;
        logic [7:0]   held_green;
        logic [15:0]  col;
        logic [15:0]  row;
        logic         format_bad;
        logic         size_bad;

        function new();
            failures     = 0;
            width_limit  = DIM_LIMIT[15:0];
            height_limit = DIM_LIMIT[15:0];
            clear_parser();
        endfunction

        function void clear_parser();
            phase        = PH_SKIP;
            token_number = '0;
            in_comment   = 1'b0;
            magic        = MAGIC_NONE;
            acc          = '0;
            flags        = '0;
            width_reg    = '0;
            height_reg   = '0;
            comp_count   = '0;
            held_red     = '0;
            held_green   = '0;
            col          = '0;
            row          = '0;
            format_bad   = 1'b0;
            size_bad     = 1'b0;
        endfunction

        function void set_limit(logic [0:0] index, logic [15:0] value);
            if (index == CFG_MAX_WIDTH)
                width_limit = value;
            else
                height_limit = value;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void push_beat(kind_t kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [15:0] x, logic [15:0] y,
                                logic [15:0] w, logic [15:0] h);
            out_data_t beat;
            beat.kind         = kind;
            beat.red_value    = r;
            beat.green_value  = g;
            beat.blue_value   = b;
            beat.column       = x;
            beat.row          = y;
            beat.image_width  = w;
            beat.image_height = h;
            beat.last         = 1'b0;
            pending_beats.push_back(beat);
        endfunction

        function void token_byte(logic [7:0] c, bit first);
            int v;
            if (token_number == '0) begin
                if (first)
                    magic = (c == CHAR_P) ? MAGIC_P : MAGIC_BAD;
                else
                    magic = (magic == MAGIC_P && c == CHAR_SIX) ? MAGIC_P6 : MAGIC_BAD;
                return;
            end
            if (first) begin
                acc   = '0;
                flags = '0;
                if (c == CHAR_MINUS) begin
                    flags.neg = 1'b1;
                    return;
                end
                if (c == CHAR_PLUS)
                    return;
            end
            if (flags.stop)
                return;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = int'(acc) * 10 + int'(c) - int'(CHAR_ZERO);
                acc = (v > int'(ACC_CAP)) ? ACC_CAP : 17'(v);
                flags.digit = 1'b1;
            end else begin
                flags.stop = 1'b1;
            end
        endfunction

        function void close_token();
            if (token_number == TOKEN_WIDTH || token_number == TOKEN_HEIGHT) begin
                if (!flags.digit)
                    format_bad = 1'b1;
                else if ((flags.neg && acc != '0) || acc > DIM_LIMIT)
                    size_bad = 1'b1;
                if (token_number == TOKEN_WIDTH)
                    width_reg = acc[15:0];
                else
                    height_reg = acc[15:0];
            end else if (token_number == LAST_TOKEN) begin
                if (!flags.digit || flags.neg || acc != MAX_VALUE)
                    format_bad = 1'b1;
            end
        endfunction

        function void check_header();
            int cap;
            int lw;
            int lh;
            cap = (1 << DIM_BITS) - 1;
            lw  = (int'(width_limit) < cap) ? int'(width_limit) : cap;
            lh  = (int'(height_limit) < cap) ? int'(height_limit) : cap;
            if (magic != MAGIC_P6 || format_bad) begin
                phase = PH_FIN;
                push_beat(KIND_FORMAT_ERROR, 0, 0, 0, 0, 0, 0, 0);
            end else if (size_bad || width_reg == '0 || height_reg == '0 ||
                         int'(width_reg) > lw || int'(height_reg) > lh) begin
                phase = PH_FIN;
                push_beat(KIND_SIZE_ERROR, 0, 0, 0, 0, 0, 0, 0);
            end else begin
                phase      = PH_PIXELS;
                comp_count = '0;
                col        = '0;
                row        = '0;
                push_beat(KIND_HEADER, 0, 0, 0, 0, 0, width_reg, height_reg);
            end
        endfunction

        function void pixel_byte(logic [7:0] c);
            int mask;
            logic [15:0] next_col;
            mask = (1 << DIM_BITS) - 1;
            if (comp_count == 2'd0) begin
                held_red   = c;
                comp_count = 2'd1;
                return;
            end
            if (comp_count == 2'd1) begin
                held_green = c;
                comp_count = 2'd2;
                return;
            end
            comp_count = 2'd0;
            push_beat(KIND_PIXEL, held_red, held_green, c, col, row, 0, 0);
            next_col = 16'((int'(col) + 1) & mask);
            if (next_col == width_reg) begin
                col = '0;
                row = 16'((int'(row) + 1) & mask);
                if (row == height_reg) begin
                    phase = PH_FIN;
                    push_beat(KIND_DONE, 0, 0, 0, 0, 0, 0, 0);
                end
            end else begin
                col = next_col;
            end
        endfunction

        function void decode_input(in_data_t item);
            int        queued;
            logic [7:0] c;
            out_data_t tail;
            queued = pending_beats.size();
            c      = item.data_byte;
            if (item.end_of_stream) begin
                if (phase == PH_SKIP || phase == PH_TOKEN) begin
                    // Only an unfinished maximum value can still complete the header.
                    if (phase == PH_TOKEN && token_number == LAST_TOKEN) begin
                        close_token();
                        check_header();
                    end else begin
                        push_beat(KIND_FORMAT_ERROR, 0, 0, 0, 0, 0, 0, 0);
                    end
                end
                if (phase == PH_PIXELS)
                    push_beat(KIND_TRUNCATED, 0, 0, 0, 0, 0, 0, 0);
                clear_parser();
            end else begin
                case (phase)
                    PH_SKIP: begin
                        if (in_comment) begin
                            if (c == CHAR_NL)
                                in_comment = 1'b0;
                        end else if (c == CHAR_HASH) begin
                            in_comment = 1'b1;
                        end else if (!is_space(c)) begin
                            token_byte(c, 1'b1);
                            phase = PH_TOKEN;
                        end
                    end
                    PH_TOKEN: begin
                        if (is_space(c) || c == CHAR_HASH) begin
                            close_token();
                            if (token_number == LAST_TOKEN) begin
                                check_header();
                                if (c == CHAR_HASH && phase == PH_PIXELS)
                                    pixel_byte(c);
                            end else begin
                                token_number = token_number + 2'd1;
                                phase        = PH_SKIP;
                                in_comment   = (c == CHAR_HASH);
                            end
                        end else begin
                            token_byte(c, 1'b0);
                        end
                    end
                    PH_PIXELS: pixel_byte(c);
                    default: ;
                endcase
            end
            if (pending_beats.size() > queued) begin
                tail      = pending_beats.pop_back();
                tail.last = 1'b1;
                pending_beats.push_back(tail);
            end
        endfunction

        function string describe(out_data_t d);
            return $sformatf("kind %0d rgb %02h %02h %02h col %0d row %0d size %0dx%0d last %0b",
                             d.kind, d.red_value, d.green_value, d.blue_value, d.column,
                             d.row, d.image_width, d.image_height, d.last);
        endfunction

        function void check_beat(out_data_t got);
            out_data_t want;
            if (pending_beats.size() == 0) begin
                if (failures < REPORT_LIMIT)
                    $display("unexpected result: %s", describe(got));
                failures++;
                return;
            end
            want = pending_beats.pop_front();
            if (got !== want) begin
                if (failures < REPORT_LIMIT)
                    $display("result mismatch: expected %s, got %s",
                             describe(want), describe(got));
                failures++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_data_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_data_t   out_data;
    logic        cfg_write = 1'b0;
    logic [0:0]  cfg_index = CFG_MAX_WIDTH;
    logic [15:0] cfg_data  = '0;

    decode_tracker tracker;
    logic [7:0]    stream_q[$];
    int            items_sent     = 0;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    int            width_cap_now  = 65535;
    int            height_cap_now = 65535;
    bit            hold_request   = 1'b0;

    ppm_p6_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                tracker.decode_input(in_data);
            if (out_valid && !out_stall)
                tracker.check_beat(out_data);
        end
    end

    // Result side: random stalls, or one long hold-off when requested.
    initial
    begin
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input in_data_t item);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Sends the queued bytes, then an end-of-stream beat that rearms the parser.
    task automatic send_stream();
        in_data_t item;
        foreach (stream_q[i]) begin
            item.data_byte     = stream_q[i];
            item.end_of_stream = 1'b0;
            send_item(item);
        end
        item.data_byte     = 8'($urandom_range(255));
        item.end_of_stream = 1'b1;
        send_item(item);
        stream_q.delete();
    endtask

    task automatic write_limits(input logic [15:0] w, input logic [15:0] h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_MAX_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_limit(CFG_MAX_WIDTH, w);
        tracker.set_limit(CFG_MAX_HEIGHT, h);
        width_cap_now  = w;
        height_cap_now = h;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(5))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    // Whitespace between tokens, sometimes with a comment that runs to a newline.
    function automatic void add_sep();
        logic [7:0] b;
        if ($urandom_range(4) == 0) begin
            stream_q.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 5)) begin
                b = 8'($urandom_range(255));
                stream_q.push_back((b == CHAR_NL) ? CHAR_P : b);
            end
            stream_q.push_back(CHAR_NL);
            if ($urandom_range(1) == 0)
                stream_q.push_back(pick_space());
        end else begin
            repeat ($urandom_range(1, 3))
                stream_q.push_back(pick_space());
        end
    endfunction

    function automatic void add_number(int v);
        int r;
        r = $urandom_range(99);
        if (r < 2) begin
            add_text("+");
            return;
        end
        if (r < 10)
            add_text("+");
        else if (r < 12)
            add_text("-");
        if ($urandom_range(9) == 0)
            add_text("00");
        add_text($sformatf("%0d", v));
        if ($urandom_range(19) == 0)
            add_text("z");
    endfunction

    function automatic int pick_dim(int limit);
        if ($urandom_range(99) < 85)
            return $urandom_range(1, (limit < 4) ? limit : 4);
        case ($urandom_range(6))
            0: return 0;
            1: return limit;
            2: return limit + 1;
            3: return 65535;
            4: return 65536;
            5: return 99999;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic random_image();
        int w;
        int h;
        int data_bytes;
        int cut;
        stream_q.delete();
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 20))
                stream_q.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0)
                add_sep();
            case ($urandom_range(39))
                0: add_text("P5");
                1: add_text("P");
                2: add_text("P66");
                3: add_text("p6");
                4: add_text("6");
                default: add_text("P6");
            endcase
            add_sep();
            w = pick_dim(width_cap_now);
            add_number(w);
            add_sep();
            h = pick_dim(height_cap_now);
            add_number(h);
            add_sep();
            case ($urandom_range(19))
                0: add_number(254);
                1: add_number(256);
                2: add_number(65536);
                default: add_number(255);
            endcase
            if (w <= 40 && h <= 40 && w * h <= 40)
                data_bytes = 3 * w * h;
            else
                data_bytes = $urandom_range(0, 12);
            // A hash right after the maximum value is already the first data byte.
            if ($urandom_range(11) == 0 && data_bytes > 0) begin
                stream_q.push_back(CHAR_HASH);
                data_bytes--;
            end else begin
                stream_q.push_back(pick_space());
            end
            repeat (data_bytes)
                stream_q.push_back(8'($urandom_range(255)));
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 3))
                    stream_q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(0, stream_q.size() - 1);
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
        send_stream();
    endtask

    initial
    begin
        int phase_start;
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 6; p++) begin
            send_gap_pct   = (p < 2) ? 13 : (p < 4) ? 69 : 0;
            recv_stall_pct = (p < 2) ? 69 : (p < 4) ? 13 : 0;
            case (p)
                0: write_limits(16'd65535, 16'd65535);
                1: write_limits(16'd1, 16'd1);
                2: write_limits(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)));
                3: write_limits(16'd65535, 16'd1);
                4: write_limits(16'd1, 16'd65535);
                default: write_limits(16'($urandom_range(1, 65535)),
                                      16'($urandom_range(1, 65535)));
            endcase
            if (p == 0) begin
                // Hash after the maximum value as pixel data, then pixel and done
                // from one byte.
                add_text("P6 1 1 255#");
                stream_q.push_back(8'h00);
                stream_q.push_back(8'hFF);
                send_stream();
                add_text("P5");
                send_stream();
                // Stream ends inside the maximum value: header, then truncated.
                add_text("P6 2 1 255");
                send_stream();
            end
            if (p == 1 || p == 4)
                hold_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                random_image();
            drain_results();
        end
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
